>>> src/lpht_pkg.sv
// Shared constants, codes and controller/datapath interface types for the hash table.
package lpht_pkg;

  localparam int TABLE_SIZE = 16;
  localparam int IDX_W      = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam bit TS_POW2    = (TABLE_SIZE & (TABLE_SIZE - 1)) == 0;

  localparam int ACT_W  = 2;
  localparam int KEY_W  = 31;
  localparam int VAL_W  = 32;
  localparam int STS_W  = 2;
  localparam int SLOT_W = 4;

  // ceil(2**(KEY_W+IDX_W) / TABLE_SIZE): exact quotient for every key
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << (KEY_W + IDX_W)) + 64'(TABLE_SIZE - 1)) / 64'(TABLE_SIZE);
  localparam logic [KEY_W:0]   RECIP  = RECIP_FULL[KEY_W:0];
  localparam logic [IDX_W-1:0] TS_MOD = IDX_W'(TABLE_SIZE);

  // action codes
  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd1;
  localparam logic [ACT_W-1:0] ACT_DELETE = 2'd2;

  // slot states
  localparam logic [1:0] ST_EMPTY = 2'd0;
  localparam logic [1:0] ST_USED  = 2'd1;
  localparam logic [1:0] ST_GONE  = 2'd2;

  // result status codes
  localparam logic [STS_W-1:0] RES_DONE     = 2'd0;
  localparam logic [STS_W-1:0] RES_NOTFOUND = 2'd1;
  localparam logic [STS_W-1:0] RES_FULL     = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_HOME  = 5'b00010,
    S_ISSUE = 5'b00100,
    S_PROBE = 5'b01000,
    S_DONE  = 5'b10000
  } lpht_state_t;

  typedef struct packed {
    logic load;       // latch the incoming word
    logic home_step;  // one step of the home slot reduction
    logic issue;      // first table read at the home slot
    logic probe;      // evaluate one probed slot
    logic out_load;   // move the result into the output register
  } lpht_cmd_t;

  typedef struct packed {
    logic home_done;
    logic probe_end;
  } lpht_sts_t;

endpackage

>>> src/linear_probe_hash_table.sv
// Top level of the linear-probing key/value hash table.
// Usage:
//   Input channel (in_valid/in_stall) carries one command word: in_action
//   (insert, lookup, delete), in_key and in_value. Result channel
//   (out_valid/out_stall) returns one word per command: out_status,
//   out_found_value and out_slot.
//   A word is taken on a clock edge with valid high and stall low.
//   Sequencing: one command is worked at a time. A command probing n slots
//   (1 to TABLE_SIZE) goes from acceptance through one table read issue,
//   n probes (one slot per cycle through the single read port of the
//   key/value memories) and a hand-over of the result to the output
//   register, where the word shows up. When TABLE_SIZE is not a power of
//   two, the home slot first comes from a two-step reciprocal multiply.
//   The output register frees the engine: a new command is accepted while
//   a result waits under out_stall; the next result then holds in the
//   engine until the output register is taken.
//   Reset (rst_n low, synchronous) marks every slot empty and drops any
//   pending result; no clearing pass is needed.
module linear_probe_hash_table (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic        [lpht_pkg::ACT_W-1:0]   in_action,
  input  logic        [lpht_pkg::KEY_W-1:0]   in_key,
  input  logic signed [lpht_pkg::VAL_W-1:0]   in_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic        [lpht_pkg::STS_W-1:0]   out_status,
  output logic signed [lpht_pkg::VAL_W-1:0]   out_found_value,
  output logic        [lpht_pkg::SLOT_W-1:0]  out_slot
);

  lpht_pkg::lpht_cmd_t cmd;
  lpht_pkg::lpht_sts_t sts;

  lpht_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  lpht_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_action       (in_action),
    .in_key          (in_key),
    .in_value        (in_value),
    .out_status      (out_status),
    .out_found_value (out_found_value),
    .out_slot        (out_slot)
  );

  // failed commands report zero value and slot
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != lpht_pkg::RES_DONE |-> out_found_value == '0 && out_slot == '0)
    else $error("failed result carries nonzero value or slot");

  // engine is busy right after taking a word
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second word accepted while a command is in flight");

  // reset drops any pending result
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

>>> src/lpht_ctrl.sv
// Sequencing state machine and channel handshake control for the hash table.
module lpht_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output lpht_pkg::lpht_cmd_t cmd,
  input  lpht_pkg::lpht_sts_t sts
);

  lpht_pkg::lpht_state_t state_r, state_nxt;
  logic                  out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != lpht_pkg::S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      lpht_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = lpht_pkg::TS_POW2 ? lpht_pkg::S_ISSUE : lpht_pkg::S_HOME;
        end
      end
      lpht_pkg::S_HOME: begin
        cmd.home_step = 1'b1;
        if (sts.home_done) state_nxt = lpht_pkg::S_ISSUE;
      end
      lpht_pkg::S_ISSUE: begin
        cmd.issue = 1'b1;
        state_nxt = lpht_pkg::S_PROBE;
      end
      lpht_pkg::S_PROBE: begin
        cmd.probe = 1'b1;
        if (sts.probe_end) state_nxt = lpht_pkg::S_DONE;
      end
      lpht_pkg::S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = lpht_pkg::S_IDLE;
        end
      end
      default: state_nxt = lpht_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load)        out_valid_nxt = 1'b1;
    else if (!out_stall)     out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lpht_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> src/lpht_dp.sv
// Datapath: slot state flops, key/value memories, probe pointer and result registers.
module lpht_dp (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  lpht_pkg::lpht_cmd_t                    cmd,
  output lpht_pkg::lpht_sts_t                    sts,
  input  logic        [lpht_pkg::ACT_W-1:0]      in_action,
  input  logic        [lpht_pkg::KEY_W-1:0]      in_key,
  input  logic signed [lpht_pkg::VAL_W-1:0]      in_value,
  output logic        [lpht_pkg::STS_W-1:0]      out_status,
  output logic signed [lpht_pkg::VAL_W-1:0]      out_found_value,
  output logic        [lpht_pkg::SLOT_W-1:0]     out_slot
);

  logic        [1:0]                 state_r [lpht_pkg::TABLE_SIZE];
  logic        [lpht_pkg::KEY_W-1:0] key_mem [lpht_pkg::TABLE_SIZE];
  logic signed [lpht_pkg::VAL_W-1:0] val_mem [lpht_pkg::TABLE_SIZE];

  logic        [lpht_pkg::ACT_W-1:0] act_r;
  logic        [lpht_pkg::KEY_W-1:0] key_r;
  logic signed [lpht_pkg::VAL_W-1:0] val_r;

  logic [lpht_pkg::IDX_W-1:0] addr_r, addr_nxt;
  logic [lpht_pkg::IDX_W-1:0] cnt_r;
  logic [lpht_pkg::IDX_W-1:0] quo_r;
  logic                       home_ph_r;
  logic [2*lpht_pkg::KEY_W:0] prod;
  logic [lpht_pkg::IDX_W-1:0] home_idx;

  logic        [lpht_pkg::IDX_W-1:0] rd_idx_r;
  logic        [1:0]                 rd_st_r;
  logic        [lpht_pkg::KEY_W-1:0] rd_key_r;
  logic signed [lpht_pkg::VAL_W-1:0] rd_val_r;

  logic        [lpht_pkg::STS_W-1:0]  res_status_r;
  logic signed [lpht_pkg::VAL_W-1:0]  res_fv_r;
  logic        [lpht_pkg::SLOT_W-1:0] res_slot_r;

  logic is_ins, is_find, is_del, hit, last, stop;

  // key / TABLE_SIZE by reciprocal multiply; the remainder is below
  // 2**IDX_W, so only the low quotient bits are kept
  assign prod = {{(lpht_pkg::KEY_W + 1){1'b0}}, key_r} *
                {{lpht_pkg::KEY_W{1'b0}}, lpht_pkg::RECIP};
  assign home_idx = key_r[lpht_pkg::IDX_W-1:0] - quo_r * lpht_pkg::TS_MOD;

  assign addr_nxt = (addr_r == lpht_pkg::IDX_W'(lpht_pkg::TABLE_SIZE - 1)) ?
                    '0 : addr_r + lpht_pkg::IDX_W'(1);

  assign is_ins  = (act_r == lpht_pkg::ACT_INSERT);
  assign is_del  = (act_r == lpht_pkg::ACT_DELETE);
  assign is_find = (act_r == lpht_pkg::ACT_LOOKUP) || is_del;
  assign last    = (cnt_r == lpht_pkg::IDX_W'(lpht_pkg::TABLE_SIZE - 1));
  assign hit     = is_ins ? (rd_st_r != lpht_pkg::ST_USED)
                          : (is_find && rd_st_r == lpht_pkg::ST_USED && rd_key_r == key_r);
  // unused action code ends at once as a miss
  assign stop    = hit || !(is_ins || is_find) ||
                   (is_find && rd_st_r == lpht_pkg::ST_EMPTY) || last;

  assign sts = '{home_done: home_ph_r, probe_end: stop};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r     <= in_action;
      key_r     <= in_key;
      val_r     <= in_value;
      home_ph_r <= 1'b0;
      if (lpht_pkg::TS_POW2) addr_r <= in_key[lpht_pkg::IDX_W-1:0];
    end
    if (cmd.home_step) begin
      home_ph_r <= 1'b1;
      if (!home_ph_r) quo_r  <= prod[lpht_pkg::KEY_W + lpht_pkg::IDX_W +: lpht_pkg::IDX_W];
      else            addr_r <= home_idx;
    end
    if (cmd.issue) begin
      addr_r <= addr_nxt;
      cnt_r  <= '0;
    end
    if (cmd.probe && !stop) begin
      addr_r <= addr_nxt;
      cnt_r  <= cnt_r + lpht_pkg::IDX_W'(1);
    end
    if (cmd.probe && stop) begin
      res_status_r <= hit ? lpht_pkg::RES_DONE
                          : (is_ins ? lpht_pkg::RES_FULL : lpht_pkg::RES_NOTFOUND);
      res_fv_r     <= (hit && is_find) ? rd_val_r : '0;
      res_slot_r   <= hit ? lpht_pkg::SLOT_W'(rd_idx_r) : '0;
    end
    if (cmd.out_load) begin
      out_status      <= res_status_r;
      out_found_value <= res_fv_r;
      out_slot        <= res_slot_r;
    end
  end

  // one read per cycle at the probe pointer
  always_ff @(posedge clk) begin
    rd_idx_r <= addr_r;
    rd_key_r <= key_mem[addr_r];
    rd_val_r <= val_mem[addr_r];
    rd_st_r  <= state_r[addr_r];
    if (cmd.probe && hit && is_ins) begin
      key_mem[rd_idx_r] <= key_r;
      val_mem[rd_idx_r] <= val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < lpht_pkg::TABLE_SIZE; i++) state_r[i] <= lpht_pkg::ST_EMPTY;
    end else if (cmd.probe && hit) begin
      if (is_ins)      state_r[rd_idx_r] <= lpht_pkg::ST_USED;
      else if (is_del) state_r[rd_idx_r] <= lpht_pkg::ST_GONE;
    end
  end

endmodule

>>> dv/tb_linear_probe_hash_table.sv
// Self-checking testbench for the linear-probing hash table: directed table, then random traffic.
`timescale 1ns / 1ps

module tb_linear_probe_hash_table;
  import lpht_pkg::*;

  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1850;
  localparam int POOL_N       = 12;
  localparam int TAIL_CYCLES  = 4 * TABLE_SIZE;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PRINT_CAP    = 40;

  typedef struct packed {
    logic [STS_W-1:0]  status;
    logic [VAL_W-1:0]  fval;
    logic [SLOT_W-1:0] slot;
  } result_t;

  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] val;
    logic [7:0]       reps;    // repeated with key and value stepping by one
    logic             typed;   // expected word given in the row
    result_t          want;
  } row_t;

  localparam result_t NOT_FOUND = '{RES_NOTFOUND, 32'h0, 4'd0};
  localparam result_t NO_WORD   = '0;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC, STALL_HOLD} stall_mode_t;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic [ACT_W-1:0]        in_action;
  logic [KEY_W-1:0]        in_key;
  logic signed [VAL_W-1:0] in_value;
  logic                    out_valid;
  logic                    out_stall;
  logic [STS_W-1:0]        out_status;
  logic signed [VAL_W-1:0] out_found_value;
  logic [SLOT_W-1:0]       out_slot;

  // expectation riding along with the payload
  logic    in_typed;
  result_t in_typed_word;

  // table as the testbench sees it
  logic [1:0]       tbl_state [TABLE_SIZE];
  logic [KEY_W-1:0] tbl_key   [TABLE_SIZE];
  logic [VAL_W-1:0] tbl_val   [TABLE_SIZE];

  result_t          pending_results [$];
  int               errors;
  int               burst_left;
  int               home_base;
  logic [KEY_W-1:0] key_pool [POOL_N];

  row_t directed_rows [19] = '{
    '{ACT_LOOKUP, 31'd0,          32'h0,        8'd1,  1'b1, NOT_FOUND},
    '{ACT_DELETE, 31'h7fffffff,   32'h0,        8'd1,  1'b1, NOT_FOUND},
    '{ACT_UNUSED, 31'd5,          32'hffffffff, 8'd1,  1'b1, NOT_FOUND},
    '{ACT_INSERT, 31'd0,          32'h7fffffff, 8'd1,  1'b1, '{RES_DONE, 32'h0, 4'd0}},
    '{ACT_INSERT, 31'h7fffffff,   32'h80000000, 8'd1,  1'b1, '{RES_DONE, 32'h0, 4'd15}},
    '{ACT_INSERT, 31'd16,         32'hffffffff, 8'd1,  1'b1, '{RES_DONE, 32'h0, 4'd1}},
    '{ACT_INSERT, 31'd0,          32'd5,        8'd1,  1'b0, NO_WORD},  // duplicate key
    '{ACT_DELETE, 31'd0,          32'h0,        8'd1,  1'b0, NO_WORD},  // first copy goes
    '{ACT_LOOKUP, 31'd0,          32'h0,        8'd1,  1'b0, NO_WORD},  // past the tombstone
    '{ACT_INSERT, 31'd32,         32'd7,        8'd1,  1'b0, NO_WORD},  // reuses tombstone
    '{ACT_LOOKUP, 31'd31,         32'h0,        8'd1,  1'b0, NO_WORD},  // wraps, then misses
    '{ACT_INSERT, 31'd47,         32'h12345678, 8'd1,  1'b0, NO_WORD},  // wraps to slot 3
    '{ACT_LOOKUP, 31'd47,         32'h0,        8'd1,  1'b0, NO_WORD},
    '{ACT_INSERT, 31'd100,        32'h5a5a0000, 8'd11, 1'b0, NO_WORD},  // fills the table
    '{ACT_INSERT, 31'd200,        32'd1,        8'd1,  1'b1, '{RES_FULL, 32'h0, 4'd0}},
    '{ACT_LOOKUP, 31'd999,        32'h0,        8'd1,  1'b1, NOT_FOUND},  // full pass
    '{ACT_UNUSED, 31'h7fffffff,   32'h80000000, 8'd1,  1'b1, NOT_FOUND},
    '{ACT_DELETE, 31'd47,         32'h0,        8'd1,  1'b0, NO_WORD},
    '{ACT_INSERT, 31'd63,         32'h0,        8'd1,  1'b0, NO_WORD}
  };

  linear_probe_hash_table dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_key          (in_key),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_found_value (out_found_value),
    .out_slot        (out_slot)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Applies one command to the table copy and returns the word it produces.
  function automatic result_t hash_op_result(input logic [ACT_W-1:0] act,
                                             input logic [KEY_W-1:0] key,
                                             input logic [VAL_W-1:0] val);
    result_t r;
    int      idx;
    r   = NOT_FOUND;
    idx = key % TABLE_SIZE;
    case (act)
      ACT_INSERT: begin
        r.status = RES_FULL;
        for (int n = 0; n < TABLE_SIZE; n++) begin
          if (tbl_state[idx] != ST_USED) begin
            tbl_state[idx] = ST_USED;
            tbl_key[idx]   = key;
            tbl_val[idx]   = val;
            r.status       = RES_DONE;
            r.slot         = SLOT_W'(idx);
            break;
          end
          idx = (idx + 1) % TABLE_SIZE;
        end
      end
      ACT_LOOKUP, ACT_DELETE: begin
        for (int n = 0; n < TABLE_SIZE; n++) begin
          if (tbl_state[idx] == ST_EMPTY) break;
          if (tbl_state[idx] == ST_USED && tbl_key[idx] == key) begin
            r.status = RES_DONE;
            r.fval   = tbl_val[idx];
            r.slot   = SLOT_W'(idx);
            if (act == ACT_DELETE) tbl_state[idx] = ST_GONE;
            break;
          end
          idx = (idx + 1) % TABLE_SIZE;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (errors < PRINT_CAP)
      $display("%0t ns  %s: got %h, want %h", $time, what, got, want);
    errors++;
  endtask

  // accepted words on both channels, sampled at the edge
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = '{out_status, out_found_value, out_slot};
        if (pending_results.size() == 0) begin
          report_mismatch("result word with none pending", 32'(got.status), 32'h0);
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status)
            report_mismatch("out_status", 32'(got.status), 32'(want.status));
          if (got.fval !== want.fval)
            report_mismatch("out_found_value", got.fval, want.fval);
          if (got.slot !== want.slot)
            report_mismatch("out_slot", 32'(got.slot), 32'(want.slot));
        end
      end
      if (in_valid && !in_stall) begin
        want = hash_op_result(in_action, in_key, in_value);
        if (in_typed) want = in_typed_word;
        pending_results.push_back(want);
      end
    end
  end

  // Offers one word, holds it until taken, then maybe leaves a gap.
  task automatic send_word(input logic [ACT_W-1:0] act, input logic [KEY_W-1:0] key,
                           input logic [VAL_W-1:0] val, input logic typed,
                           input result_t typed_want);
    int gap;
    in_valid      <= 1'b1;
    in_action     <= act;
    in_key        <= key;
    in_value      <= val;
    in_typed      <= typed;
    in_typed_word <= typed_want;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic void refresh_pool_entry(input int i);
    logic [KEY_W-1:0] k;
    k = KEY_W'($urandom);
    k[IDX_W-1:0] = IDX_W'(home_base + $urandom_range(0, 3));
    key_pool[i] = k;
  endfunction

  // Mostly clustered keys so probes collide; some live keys, some wild ones.
  function automatic logic [KEY_W-1:0] pick_key();
    logic [KEY_W-1:0] k;
    int               r;
    int               s;
    r = $urandom_range(0, 99);
    s = $urandom_range(0, TABLE_SIZE - 1);
    if (r < 30 && tbl_state[s] == ST_USED) k = tbl_key[s];
    else if (r < 85) k = key_pool[$urandom_range(0, POOL_N - 1)];
    else if (r < 93) k = KEY_W'($urandom);
    else begin
      case ($urandom_range(0, 2))
        0:       k = '0;
        1:       k = '1;
        default: k = KEY_W'($urandom_range(0, 2 * TABLE_SIZE));
      endcase
    end
    return k;
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    if ($urandom_range(0, 9) != 0) return $urandom;
    case ($urandom_range(0, 3))
      0:       return 32'h80000000;
      1:       return 32'h7fffffff;
      2:       return 32'h0;
      default: return 32'hffffffff;
    endcase
  endfunction

  task automatic run_random(input int count);
    int               ins_pct;
    int               del_pct;
    int               r;
    logic [ACT_W-1:0] act;
    ins_pct = 40;
    del_pct = 25;
    for (int i = 0; i < count; i++) begin
      if (i % 150 == 0) begin
        ins_pct   = $urandom_range(15, 65);
        del_pct   = $urandom_range(10, 40);
        home_base = $urandom_range(0, TABLE_SIZE - 1);
      end
      if (i % 10 == 0) refresh_pool_entry($urandom_range(0, POOL_N - 1));
      if (i == count / 3) drain_results();
      r = $urandom_range(0, 99);
      if (r < 4) act = ACT_UNUSED;
      else if (r < 4 + ins_pct) act = ACT_INSERT;
      else if (r < 4 + ins_pct + del_pct) act = ACT_DELETE;
      else act = ACT_LOOKUP;
      send_word(act, pick_key(), pick_value(), 1'b0, NO_WORD);
    end
  endtask

  // receiver stall pattern, segment by segment
  initial begin
    int          seg_len;
    int          segs;
    int          period;
    stall_mode_t mode;
    out_stall <= 1'b0;
    segs = 0;
    @(posedge clk);
    forever begin
      segs++;
      seg_len = $urandom_range(10, 120);
      period  = $urandom_range(2, 5);
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5:       mode = STALL_NONE;
        6, 7, 8, 9, 10, 11:     mode = STALL_LIGHT;
        12, 13, 14, 15:         mode = STALL_HEAVY;
        16, 17, 18:             mode = STALL_PERIODIC;
        default:                mode = STALL_HOLD;
      endcase
      if (segs == 3) mode = STALL_HOLD;
      if (mode == STALL_HOLD) begin
        // long hold-off so the block backs up into in_stall
        out_stall <= 1'b1;
        repeat ($urandom_range(150, 300)) @(posedge clk);
      end else begin
        for (int c = 0; c < seg_len; c++) begin
          case (mode)
            STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
            STALL_PERIODIC: out_stall <= ((c % period) == 0);
            default:        out_stall <= 1'b0;
          endcase
          @(posedge clk);
        end
      end
    end
  end

  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb_linear_probe_hash_table: done, errors");
    $finish;
  end

  initial begin
    errors     = 0;
    burst_left = 1;
    home_base  = 0;
    foreach (tbl_state[i]) tbl_state[i] = ST_EMPTY;
    foreach (key_pool[i]) refresh_pool_entry(i);
    in_valid      <= 1'b0;
    in_action     <= ACT_INSERT;
    in_key        <= '0;
    in_value      <= '0;
    in_typed      <= 1'b0;
    in_typed_word <= NO_WORD;
    rst_n         <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      for (int r = 0; r < directed_rows[i].reps; r++)
        send_word(directed_rows[i].act, directed_rows[i].key + KEY_W'(r),
                  directed_rows[i].val + VAL_W'(r), directed_rows[i].typed,
                  directed_rows[i].want);
    end
    drain_results();

    run_random(RANDOM_ITEMS);
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (pending_results.size() != 0)
      report_mismatch("words still pending", pending_results.size(), 32'h0);
    if (errors == 0)
      $display("tb_linear_probe_hash_table: done, clean");
    else
      $display("tb_linear_probe_hash_table: done, errors");
    $finish;
  end

endmodule
